[design/array_linked_list_manager_top_defines.svh]
// Assertion macros used by the checker file.
`ifndef ARRAY_LINKED_LIST_MANAGER_TOP_DEFINES_SVH
`define ARRAY_LINKED_LIST_MANAGER_TOP_DEFINES_SVH

// Assert that an implication holds at every clock edge outside reset.
`define ALM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert that an implication holds in the cycle after the antecedent, outside reset.
`define ALM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/allm_pkg.sv]
package allm_pkg;

    localparam int Capacity  = 64;
    localparam int SlotW     = $clog2(Capacity);
    localparam int CountW    = $clog2(Capacity + 1);
    localparam int ItemW     = 32;

    // Operation codes.
    localparam logic [3:0] OP_APPEND = 4'd0;
    localparam logic [3:0] OP_INS_BF = 4'd1;
    localparam logic [3:0] OP_INS_AF = 4'd2;
    localparam logic [3:0] OP_ERASE  = 4'd3;
    localparam logic [3:0] OP_READ   = 4'd4;
    localparam logic [3:0] OP_AT_POS = 4'd5;
    localparam logic [3:0] OP_IDX_OF = 4'd6;
    localparam logic [3:0] OP_NEXT   = 4'd7;
    localparam logic [3:0] OP_PREV   = 4'd8;
    localparam logic [3:0] OP_FIRST  = 4'd9;
    localparam logic [3:0] OP_LAST   = 4'd10;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    // Walk request from the sequencer to the list walker.
    typedef struct packed {
        logic              start;
        logic              by_pos;
        logic [SlotW-1:0]  target;
        logic [SlotW-1:0]  pos;
        logic [SlotW-1:0]  head;
        logic [CountW-1:0] count;
    } t_walk_req;

    // Walk outcome: done and found flags, predecessor, position and slot reached.
    typedef struct packed {
        logic              done;
        logic              found;
        logic              has_prev;
        logic [SlotW-1:0]  prev;
        logic [SlotW-1:0]  pos;
        logic [SlotW-1:0]  slot;
    } t_walk_rsp;

endpackage

[design/array_linked_list_manager_top.sv]
// Channel | Dir | tdata bits (low first)                         | tuser
// s_axis  | in  | operation[3:0] node[9:4] position[15:10] item[47:16] | -
// m_axis  | out | status[1:0] result_node[7:2] result_position[13:8]
//         |     | result_item[45:14] list_length[52:46], zero [55:53] | -
// An accepted item first has the lowest free slot latched and is screened; an
// item rejected there goes straight to the result. Otherwise the node's link is
// read; index of, previous, at position, erase and insert before then walk the
// links from the head, taking longer the more links are visited. Append and the
// inserts write the new slot and then any second link before the result beat.
// Reset is synchronous, active low, and clears the occupied bits, head, tail
// and count at once. A waiting result holds until taken; no item is accepted
// meanwhile, and the next beat can be taken the cycle after the result leaves.
module array_linked_list_manager_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // operation, node, position, item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // status, node, position, item, length
);
    localparam int SW = allm_pkg::SlotW;
    localparam int CW = allm_pkg::CountW;
    localparam int IW = allm_pkg::ItemW;
    localparam int Capacity_m1 = allm_pkg::Capacity - 1;

    typedef enum logic [3:0] {
        S_IDLE, S_FREE, S_RDN, S_RDW, S_WALK, S_WWAIT, S_APPLY, S_LINK2, S_OUT
    } t_state;

    t_state               r_state;
    logic [3:0]           r_op;
    logic [SW-1:0]        r_node;
    logic [SW-1:0]        r_pos;
    logic [IW-1:0]        r_item;
    logic [Capacity_m1:0] r_occ;
    logic [SW:0]          r_first;
    logic [SW:0]          r_last;
    logic [CW-1:0]        r_count;
    logic [SW-1:0]        r_free;
    logic [SW-1:0]        n_free;
    logic [SW:0]          r_nlink;
    logic [1:0]           r_st;
    logic [SW-1:0]        r_rnode;
    logic [SW-1:0]        r_rpos;
    logic [IW-1:0]        r_ritem;
    logic                 r_ovalid;
    logic [55:0]          r_odata;

    // Link and content memories.
    logic [SW:0]   r_link_mem [allm_pkg::Capacity];
    logic [IW-1:0] r_cont_mem [allm_pkg::Capacity];
    logic [SW:0]   r_link_q;
    logic [IW-1:0] r_cont_q;
    logic [SW-1:0] n_rd_addr;
    logic          n_lwe;
    logic [SW-1:0] n_lwa;
    logic [SW:0]   n_lwd;
    logic          n_cwe;

    allm_pkg::t_walk_req n_req;
    allm_pkg::t_walk_rsp w_rsp;
    logic [SW-1:0]       w_addr;
    logic                w_busy;

    logic          n_valid_node;
    logic          n_needs_node;
    logic          n_in_acc;

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign n_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    assign n_valid_node = r_occ[r_node];
    assign n_needs_node = (r_op == allm_pkg::OP_INS_BF) || (r_op == allm_pkg::OP_INS_AF) ||
                          (r_op == allm_pkg::OP_ERASE) || (r_op == allm_pkg::OP_READ) ||
                          (r_op == allm_pkg::OP_IDX_OF) || (r_op == allm_pkg::OP_NEXT) ||
                          (r_op == allm_pkg::OP_PREV);

    allm_walker u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (n_req),
        .i_link    (r_link_q),
        .o_rd_addr (w_addr),
        .o_busy    (w_busy),
        .o_rsp     (w_rsp)
    );

    always_comb begin
        n_req        = '0;
        n_req.start  = (r_state == S_WALK);
        n_req.by_pos = (r_op == allm_pkg::OP_AT_POS);
        n_req.target = r_node;
        n_req.pos    = r_pos;
        n_req.head   = r_first[SW-1:0];
        n_req.count  = r_count;
        n_rd_addr    = w_busy ? w_addr : r_node;
    end

    // Priority search for the lowest free slot.
    always_comb begin
        n_free = '0;
        for (int k = allm_pkg::Capacity - 1; k >= 0; k--) begin
            if (!r_occ[k]) begin
                n_free = SW'(k);
            end
        end
    end

    // Memories: one write port each, registered read.
    always_ff @(posedge i_clk) begin
        if (n_lwe) begin
            r_link_mem[n_lwa] <= n_lwd;
        end
        if (n_cwe) begin
            r_cont_mem[r_free] <= r_item;
        end
        r_link_q <= r_link_mem[n_rd_addr];
        r_cont_q <= r_cont_mem[n_rd_addr];
    end

    // Link writes issued by the sequencer.
    always_comb begin
        n_lwe = 1'b0;
        n_lwa = r_free;
        n_lwd = '0;
        n_cwe = 1'b0;
        if (r_state == S_APPLY && r_st == allm_pkg::ST_OK) begin
            case (r_op)
                allm_pkg::OP_APPEND: begin
                    n_lwe = 1'b1; n_lwd = {1'b1, {SW{1'b0}}}; n_cwe = 1'b1;
                end
                allm_pkg::OP_INS_BF: begin
                    n_lwe = 1'b1; n_lwd = {1'b0, r_node}; n_cwe = 1'b1;
                end
                allm_pkg::OP_INS_AF: begin
                    n_lwe = 1'b1; n_lwd = r_nlink; n_cwe = 1'b1;
                end
                allm_pkg::OP_ERASE: begin
                    n_lwe = w_rsp.has_prev && (r_first[SW-1:0] != r_node || r_first[SW]);
                    n_lwa = w_rsp.prev; n_lwd = r_nlink;
                end
                default: ;
            endcase
        end else if (r_state == S_LINK2) begin
            case (r_op)
                allm_pkg::OP_APPEND: begin
                    n_lwe = !r_last[SW]; n_lwa = r_last[SW-1:0]; n_lwd = {1'b0, r_free};
                end
                allm_pkg::OP_INS_BF: begin
                    // Only a node with a predecessor needs that link moved.
                    n_lwe = w_rsp.has_prev;
                    n_lwa = w_rsp.prev; n_lwd = {1'b0, r_free};
                end
                allm_pkg::OP_INS_AF: begin
                    n_lwe = 1'b1; n_lwa = r_node; n_lwd = {1'b0, r_free};
                end
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_occ      <= '0;
            r_first    <= {1'b1, {SW{1'b0}}};
            r_last     <= {1'b1, {SW{1'b0}}};
            r_count    <= '0;
            r_ovalid   <= 1'b0;
            r_st       <= allm_pkg::ST_OK;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_in_acc) begin
                        r_op    <= s_axis_tdata[3:0];
                        r_node  <= s_axis_tdata[9:4];
                        r_pos   <= s_axis_tdata[15:10];
                        r_item  <= s_axis_tdata[47:16];
                        r_st    <= allm_pkg::ST_OK;
                        r_rnode <= '0;
                        r_rpos  <= '0;
                        r_ritem <= '0;
                        r_state <= S_FREE;
                    end
                end
                S_FREE: begin
                    // Latch the lowest free slot and screen the request.
                    r_free <= n_free;
                    if (r_op > allm_pkg::OP_LAST || (n_needs_node && !n_valid_node)) begin
                        r_st    <= allm_pkg::ST_INVALID;
                        r_state <= S_OUT;
                    end else if (r_op <= allm_pkg::OP_INS_AF &&
                                 r_count >= CW'(allm_pkg::Capacity)) begin
                        r_st    <= allm_pkg::ST_FULL;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_RDN;
                    end
                end
                S_RDN: r_state <= S_RDW;
                S_RDW: begin
                    r_nlink <= r_link_q;
                    case (r_op) inside
                        allm_pkg::OP_APPEND, allm_pkg::OP_INS_AF: r_state <= S_APPLY;
                        allm_pkg::OP_INS_BF, allm_pkg::OP_ERASE, allm_pkg::OP_AT_POS,
                        allm_pkg::OP_IDX_OF, allm_pkg::OP_PREV: begin
                            if (r_op == allm_pkg::OP_AT_POS && {1'b0, r_pos} >= r_count) begin
                                r_st    <= allm_pkg::ST_INVALID;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_WALK;
                            end
                        end
                        allm_pkg::OP_READ: begin
                            r_rnode <= r_node; r_ritem <= r_cont_q;
                            r_state <= S_OUT;
                        end
                        allm_pkg::OP_NEXT: begin
                            if ((r_last == {1'b0, r_node}) || r_link_q[SW]) begin
                                r_st <= allm_pkg::ST_NONE;
                            end else begin
                                r_rnode <= r_link_q[SW-1:0];
                            end
                            r_state <= S_OUT;
                        end
                        allm_pkg::OP_FIRST: begin
                            if (r_count == '0 || r_first[SW]) r_st <= allm_pkg::ST_NONE;
                            else r_rnode <= r_first[SW-1:0];
                            r_state <= S_OUT;
                        end
                        allm_pkg::OP_LAST: begin
                            if (r_count == '0 || r_last[SW]) r_st <= allm_pkg::ST_NONE;
                            else r_rnode <= r_last[SW-1:0];
                            r_state <= S_OUT;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_WALK: r_state <= S_WWAIT;
                S_WWAIT: begin
                    if (w_rsp.done) begin
                        case (r_op) inside
                            allm_pkg::OP_INS_BF, allm_pkg::OP_ERASE: r_state <= S_APPLY;
                            allm_pkg::OP_AT_POS: begin
                                if (w_rsp.found) r_rnode <= w_rsp.slot;
                                else r_st <= allm_pkg::ST_INVALID;
                                r_state <= S_OUT;
                            end
                            allm_pkg::OP_IDX_OF: begin
                                r_rnode <= r_node;
                                r_rpos  <= w_rsp.found ? w_rsp.pos : '0;
                                r_state <= S_OUT;
                            end
                            default: begin
                                if ((r_first == {1'b0, r_node}) || !w_rsp.has_prev) begin
                                    r_st <= allm_pkg::ST_NONE;
                                end else begin
                                    r_rnode <= w_rsp.prev;
                                end
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_APPLY: begin
                    case (r_op)
                        allm_pkg::OP_ERASE: begin
                            r_state <= S_OUT;
                            r_rnode <= r_node;
                            r_occ[r_node] <= 1'b0;
                            if (r_count <= CW'(1)) begin
                                r_count <= '0;
                                r_first <= {1'b1, {SW{1'b0}}};
                                r_last  <= {1'b1, {SW{1'b0}}};
                            end else begin
                                r_count <= r_count - 1'b1;
                                if (r_first == {1'b0, r_node}) r_first <= r_nlink;
                                if (r_last == {1'b0, r_node}) begin
                                    r_last <= w_rsp.has_prev ? {1'b0, w_rsp.prev}
                                                             : {1'b1, {SW{1'b0}}};
                                end
                            end
                        end
                        default: begin
                            // Append and inserts: take the free slot.
                            r_rnode       <= r_free;
                            r_occ[r_free] <= 1'b1;
                            r_count       <= r_count + 1'b1;
                            r_state       <= S_LINK2;
                            if (r_op == allm_pkg::OP_INS_BF) begin
                                if ((r_first == {1'b0, r_node}) || !w_rsp.has_prev) begin
                                    r_first <= {1'b0, r_free};
                                end
                            end
                            if (r_op == allm_pkg::OP_APPEND && r_last[SW]) begin
                                r_first <= {1'b0, r_free};
                            end
                            if (r_op == allm_pkg::OP_INS_AF && r_last == {1'b0, r_node}) begin
                                r_last <= {1'b0, r_free};
                            end
                        end
                    endcase
                end
                S_LINK2: begin
                    // The old tail is linked in this cycle, so the tail moves now.
                    if (r_op == allm_pkg::OP_APPEND) r_last <= {1'b0, r_free};
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {3'b000, r_count,
                                     (r_st == allm_pkg::ST_OK) ? r_ritem : {IW{1'b0}},
                                     (r_st == allm_pkg::ST_OK) ? r_rpos  : {SW{1'b0}},
                                     (r_st == allm_pkg::ST_OK) ? r_rnode : {SW{1'b0}},
                                     r_st};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[design/allm_walker.sv]
// List walker: follows the links from the head through the shared link-memory
// read port until the target slot or position is reached or the list ends.
module allm_walker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  allm_pkg::t_walk_req          i_req,
    input  logic [allm_pkg::SlotW:0]     i_link,
    output logic [allm_pkg::SlotW-1:0]   o_rd_addr,
    output logic                         o_busy,
    output allm_pkg::t_walk_rsp          o_rsp
);
    typedef enum logic [1:0] {W_IDLE, W_READ, W_STEP} t_wstate;

    t_wstate                     r_state;
    logic [allm_pkg::SlotW-1:0]  r_cur;
    logic [allm_pkg::SlotW-1:0]  r_prev;
    logic                        r_has_prev;
    logic [allm_pkg::CountW-1:0] r_idx;
    logic                        r_by_pos;
    logic [allm_pkg::SlotW-1:0]  r_target;
    logic [allm_pkg::SlotW-1:0]  r_pos;
    logic [allm_pkg::CountW-1:0] r_count;
    allm_pkg::t_walk_rsp         r_rsp;
    logic                        n_hit;

    assign o_rd_addr = r_cur;
    assign o_busy    = (r_state != W_IDLE);
    assign o_rsp     = r_rsp;

    always_comb begin
        if (r_by_pos) begin
            n_hit = (r_idx == {1'b0, r_pos});
        end else begin
            n_hit = (r_cur == r_target);
        end
    end

    // One link is fetched per step: address, then registered data.
    // The done flag is a one-cycle pulse; the other response fields hold.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= W_IDLE;
            r_rsp      <= '0;
            r_cur      <= '0;
            r_prev     <= '0;
            r_has_prev <= 1'b0;
            r_idx      <= '0;
            r_by_pos   <= 1'b0;
            r_target   <= '0;
            r_pos      <= '0;
            r_count    <= '0;
        end else begin
            unique case (r_state)
                W_IDLE: begin
                    if (i_req.start) begin
                        r_cur      <= i_req.head;
                        r_prev     <= '0;
                        r_has_prev <= 1'b0;
                        r_idx      <= '0;
                        r_by_pos   <= i_req.by_pos;
                        r_target   <= i_req.target;
                        r_pos      <= i_req.pos;
                        r_count    <= i_req.count;
                        if (i_req.count == '0) begin
                            r_rsp <= '{done: 1'b1, found: 1'b0, has_prev: 1'b0,
                                       prev: '0, pos: '0, slot: '0};
                        end else begin
                            r_rsp.done <= 1'b0;
                            r_state    <= W_READ;
                        end
                    end else begin
                        r_rsp.done <= 1'b0;
                    end
                end
                W_READ: begin
                    if (n_hit) begin
                        r_rsp <= '{done: 1'b1, found: 1'b1, has_prev: r_has_prev,
                                   prev: r_prev, pos: r_idx[allm_pkg::SlotW-1:0],
                                   slot: r_cur};
                        r_state <= W_IDLE;
                    end else begin
                        r_rsp.done <= 1'b0;
                        r_state    <= W_STEP;
                    end
                end
                W_STEP: begin
                    if ((r_idx + 1'b1 >= r_count) || i_link[allm_pkg::SlotW]) begin
                        r_rsp <= '{done: 1'b1, found: 1'b0, has_prev: 1'b0,
                                   prev: '0, pos: '0, slot: '0};
                        r_state <= W_IDLE;
                    end else begin
                        r_rsp.done <= 1'b0;
                        r_prev     <= r_cur;
                        r_has_prev <= 1'b1;
                        r_cur      <= i_link[allm_pkg::SlotW-1:0];
                        r_idx      <= r_idx + 1'b1;
                        r_state    <= W_READ;
                    end
                end
                default: r_state <= W_IDLE;
            endcase
        end
    end
endmodule

[design/allm_checker.sv]
`include "array_linked_list_manager_top_defines.svh"
// Port-level checks on the list manager.
module allm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    `ALM_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
    `ALM_ASSERT_IMPL(a_no_in_with_out, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "input ready while result waits")
    `ALM_ASSERT_IMPL(a_len_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[52:46] <= 7'd64, "length out of range")
    `ALM_ASSERT_IMPL(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[55:53] == 3'd0, "padding not zero")
endmodule

bind array_linked_list_manager_top allm_checker u_allm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int Capacity = allm_pkg::Capacity;
    localparam int NoneSlot = Capacity;
    localparam int CycleLimit = 2000000;

    // Result fields, lowest bits last so the struct lines up with tdata.
    typedef struct packed {
        logic [6:0]  length;
        logic [31:0] item;
        logic [5:0]  pos;
        logic [5:0]  node;
        logic [1:0]  status;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // operation, node, position, item
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // status, node, position, item, length

    array_linked_list_manager_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Shadow copy of the list.
    int        next_of [Capacity];
    bit [31:0] word_of [Capacity];
    bit        used    [Capacity];
    int        head_slot, tail_slot, list_count;

    t_answer answers_due[$];
    int      mismatch_count;
    int      result_count;
    int      cycle_count;
    bit      hold_receiver;
    int      hold_cycles;
    int      ops_seen [16];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic int free_slot();
        for (int i = 0; i < Capacity; i++)
            if (!used[i]) return i;
        return NoneSlot;
    endfunction

    // Walk from the head; returns predecessor of s and its position.
    function automatic int find_pred(int s, output int at);
        int cur;
        int prv;
        cur = head_slot;
        prv = NoneSlot;
        at = 0;
        for (int i = 0; i < list_count && cur < Capacity; i++) begin
            if (cur == s) begin
                at = i;
                return prv;
            end
            prv = cur;
            cur = next_of[cur];
        end
        at = 0;
        return NoneSlot;
    endfunction

    // Applies one operation to the shadow list and returns its answer.
    function automatic t_answer apply_op(logic [3:0] op, int nd, int ps, logic [31:0] it);
        t_answer a;
        int slot;
        int prv;
        int at;
        int cur;
        bit wants_node;
        a = '0;
        wants_node = (op >= allm_pkg::OP_INS_BF && op <= allm_pkg::OP_READ) ||
                     op == allm_pkg::OP_IDX_OF || op == allm_pkg::OP_NEXT ||
                     op == allm_pkg::OP_PREV;
        if (op > allm_pkg::OP_LAST) begin
            a.status = allm_pkg::ST_INVALID;
        end else if (wants_node && !used[nd]) begin
            a.status = allm_pkg::ST_INVALID;
        end else if (op <= allm_pkg::OP_INS_AF && list_count >= Capacity) begin
            a.status = allm_pkg::ST_FULL;
        end else begin
            case (op)
                allm_pkg::OP_APPEND: begin
                    slot = free_slot();
                    used[slot] = 1; word_of[slot] = it; list_count++;
                    next_of[slot] = NoneSlot;
                    if (tail_slot < Capacity) next_of[tail_slot] = slot;
                    else head_slot = slot;
                    tail_slot = slot;
                    a.node = 6'(slot);
                end
                allm_pkg::OP_INS_BF: begin
                    slot = free_slot();
                    prv = find_pred(nd, at);
                    used[slot] = 1; word_of[slot] = it; list_count++;
                    next_of[slot] = nd;
                    if (nd == head_slot || prv >= Capacity) head_slot = slot;
                    else next_of[prv] = slot;
                    a.node = 6'(slot);
                end
                allm_pkg::OP_INS_AF: begin
                    slot = free_slot();
                    used[slot] = 1; word_of[slot] = it; list_count++;
                    next_of[slot] = next_of[nd];
                    next_of[nd] = slot;
                    if (nd == tail_slot) tail_slot = slot;
                    a.node = 6'(slot);
                end
                allm_pkg::OP_ERASE: begin
                    prv = find_pred(nd, at);
                    if (nd == head_slot) head_slot = next_of[nd];
                    else if (prv < Capacity) next_of[prv] = next_of[nd];
                    if (nd == tail_slot) tail_slot = prv;
                    used[nd] = 0;
                    if (list_count > 0) list_count--;
                    if (list_count == 0) begin
                        head_slot = NoneSlot;
                        tail_slot = NoneSlot;
                    end
                    a.node = 6'(nd);
                end
                allm_pkg::OP_READ: begin
                    a.node = 6'(nd);
                    a.item = word_of[nd];
                end
                allm_pkg::OP_AT_POS: begin
                    if (ps >= list_count) begin
                        a.status = allm_pkg::ST_INVALID;
                    end else begin
                        cur = head_slot;
                        for (int i = 0; i < ps && cur < Capacity; i++) cur = next_of[cur];
                        if (cur >= Capacity) a.status = allm_pkg::ST_INVALID;
                        else a.node = 6'(cur);
                    end
                end
                allm_pkg::OP_IDX_OF: begin
                    prv = find_pred(nd, at);
                    a.node = 6'(nd);
                    a.pos = 6'(at);
                end
                allm_pkg::OP_NEXT: begin
                    if (nd == tail_slot || next_of[nd] >= Capacity)
                        a.status = allm_pkg::ST_NONE;
                    else a.node = 6'(next_of[nd]);
                end
                allm_pkg::OP_PREV: begin
                    prv = find_pred(nd, at);
                    if (nd == head_slot || prv >= Capacity) a.status = allm_pkg::ST_NONE;
                    else a.node = 6'(prv);
                end
                allm_pkg::OP_FIRST: begin
                    if (list_count == 0 || head_slot >= Capacity) a.status = allm_pkg::ST_NONE;
                    else a.node = 6'(head_slot);
                end
                default: begin
                    if (list_count == 0 || tail_slot >= Capacity) a.status = allm_pkg::ST_NONE;
                    else a.node = 6'(tail_slot);
                end
            endcase
        end
        if (a.status != allm_pkg::ST_OK) begin
            a.node = 0;
            a.pos = 0;
            a.item = 0;
        end
        a.length = 7'(list_count);
        return a;
    endfunction

    // Sends one beat, predicting its answer at the moment it is taken.
    task automatic send_op(logic [3:0] op, int nd, int ps, logic [31:0] it);
        t_answer a;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it, ps[5:0], nd[5:0], op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        a = apply_op(op, nd, ps, it);
        answers_due.push_back(a);
        ops_seen[op]++;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random gap of the sender, none most of the time.
    task automatic sender_gap();
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    // Picks an occupied slot, or any slot when random tries find none, as on an empty list.
    function automatic int pick_live();
        int tries;
        int s;
        for (tries = 0; tries < 200; tries++) begin
            s = int'($urandom_range(0, Capacity - 1));
            if (used[s]) return s;
        end
        return int'($urandom_range(0, Capacity - 1));
    endfunction

    task automatic drain();
        while (answers_due.size() != 0) @(posedge i_clk);
    endtask

    // Receiver stall pattern, with an optional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= 0;
        end else if (hold_receiver && hold_cycles < 400) begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= hold_cycles + 1;
        end else begin
            m_axis_tready <= (cycle_count % 512 < 128) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[52:0];
            result_count++;
            if (answers_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat %h", m_axis_tdata);
            end else begin
                want = answers_due.pop_front();
                if (got !== want || m_axis_tdata[55:53] !== 3'b0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected st=%0d node=%0d pos=%0d item=%h len=%0d,",
                            want.status, want.node, want.pos, want.item, want.length);
                        $display("          got st=%0d node=%0d pos=%0d item=%h len=%0d",
                            got.status, got.node, got.pos, got.item, got.length);
                    end
                end
            end
        end
    end

    // Empty-list cases, field extremes and every operation on a small list.
    task automatic test_directed();
        send_op(allm_pkg::OP_FIRST, 0, 0, 0);
        send_op(allm_pkg::OP_LAST, 0, 0, 0);
        send_op(allm_pkg::OP_READ, 63, 0, 0);
        send_op(allm_pkg::OP_AT_POS, 0, 0, 0);
        send_op(allm_pkg::OP_APPEND, 63, 63, 32'hFFFF_FFFF);
        send_op(allm_pkg::OP_APPEND, 0, 0, 32'h0000_0000);
        send_op(allm_pkg::OP_INS_BF, 0, 0, 32'hA5A5_5A5A);
        send_op(allm_pkg::OP_INS_AF, 1, 0, 32'h1234_5678);
        send_op(allm_pkg::OP_READ, 2, 0, 0);
        send_op(allm_pkg::OP_AT_POS, 0, 3, 0);
        send_op(allm_pkg::OP_AT_POS, 0, 63, 0);
        send_op(allm_pkg::OP_IDX_OF, 3, 0, 0);
        send_op(allm_pkg::OP_NEXT, 3, 0, 0);
        send_op(allm_pkg::OP_PREV, 2, 0, 0);
        send_op(allm_pkg::OP_PREV, 0, 0, 0);
        send_op(allm_pkg::OP_ERASE, 2, 0, 0);
        send_op(allm_pkg::OP_ERASE, 3, 0, 0);
        send_op(allm_pkg::OP_ERASE, 40, 0, 0);
        send_op(4'd11, 0, 0, 0);
        send_op(4'd15, 63, 63, 32'hFFFF_FFFF);
        send_op(allm_pkg::OP_ERASE, 0, 0, 0);
        send_op(allm_pkg::OP_ERASE, 1, 0, 0);
        send_op(allm_pkg::OP_LAST, 0, 0, 0);
        drain();
    endtask

    // Fill the list to capacity, then try to grow it further and query near its tail.
    task automatic test_full_list();
        while (list_count < Capacity) begin
            send_op(allm_pkg::OP_APPEND, 0, 0, $urandom);
            sender_gap();
        end
        send_op(allm_pkg::OP_APPEND, 0, 0, $urandom);
        send_op(allm_pkg::OP_INS_BF, 5, 0, $urandom);
        send_op(allm_pkg::OP_INS_AF, 63, 0, $urandom);
        send_op(allm_pkg::OP_AT_POS, 0, 63, 0);
        send_op(allm_pkg::OP_PREV, tail_slot, 0, 0);
        drain();
    endtask

    // Receiver holds off while the sender keeps offering.
    task automatic test_backpressure();
        hold_receiver = 1'b1;
        repeat (12)
            send_op(4'($urandom_range(allm_pkg::OP_READ, allm_pkg::OP_LAST)),
                    pick_live(), 0, 0);
        hold_receiver = 1'b0;
        drain();
    endtask

    // Random mix, mostly well-formed with live nodes.
    task automatic test_random(int count);
        logic [3:0] op;
        int nd;
        int ps;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 19) == 0)
                op = 4'($urandom_range(0, 15));
            else if (list_count > 48)
                op = 4'($urandom_range(allm_pkg::OP_INS_AF, allm_pkg::OP_LAST));
            else
                op = 4'($urandom_range(allm_pkg::OP_APPEND, allm_pkg::OP_LAST));
            nd = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 63)) : pick_live();
            ps = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 63))
                                             : int'($urandom_range(0, list_count + 1));
            if (ps > 63) ps = 63;
            send_op(op, nd, ps, $urandom);
            sender_gap();
            if (n % 400 == 399) drain();
        end
        drain();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        hold_receiver  = 1'b0;
        mismatch_count = 0;
        result_count   = 0;
        cycle_count    = 0;
        head_slot      = NoneSlot;
        tail_slot      = NoneSlot;
        list_count     = 0;
        for (int i = 0; i < Capacity; i++) begin
            used[i] = 0; next_of[i] = NoneSlot; word_of[i] = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_list();
        test_backpressure();
        test_random(1500);

        repeat (200) @(posedge i_clk);
        $display("covered %0d results: every operation code, empty and full lists,", result_count);
        $display("head and tail edits, invalid nodes and positions, and a long receiver hold-off");
        if (mismatch_count == 0 && answers_due.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
